/* rtl/core/text_cell_number_writer_defines.svh */
// Assertion macros for the text cell number writer
`ifndef TEXT_CELL_NUMBER_WRITER_DEFINES_SVH
`define TEXT_CELL_NUMBER_WRITER_DEFINES_SVH
`ifndef SYNTHESIS
`define TCNW_ASSERT(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("tcnw assertion failed");
`define TCNW_ASSERT_ALWAYS(label, clk, prop) \
  label: assert property (@(posedge clk) prop) \
    else $error("tcnw assertion failed");
`else
`define TCNW_ASSERT(label, clk, rst_n, prop)
`define TCNW_ASSERT_ALWAYS(label, clk, prop)
`endif
`endif

/* rtl/core/tcnw_pkg.sv */
// Types, constants and functions shared by the text cell number writer
`timescale 1ns / 1ps
package tcnw_pkg;

  localparam int unsigned NUM_DIGITS = 5;
  localparam int unsigned CNT_W      = 3;
  localparam int unsigned QDEPTH     = 2;

  localparam logic [7:0]  DIGIT_ZERO  = 8'd48;
  localparam logic [7:0]  DIGIT_NINE  = 8'd57;
  localparam logic [15:0] DIV10_MUL   = 16'd52429;
  localparam int unsigned DIV10_SHIFT = 19;

  typedef logic [3:0] digit_t;

  typedef enum logic [1:0] {
    FS_IDLE,
    FS_CONV,
    FS_PUSH
  } front_state_e;

  typedef struct packed {
    logic [15:0]                       base;
    logic [7:0]                        column;
    logic [7:0]                        colour;
    logic                              is_num;
    logic [7:0]                        code;
    logic [NUM_DIGITS-1:0][3:0]        digits;
    logic [CNT_W-1:0]                  count;
  } cmd_t;

  function automatic logic [7:0] map_code(input logic [7:0] code);
    logic [7:0] res;
    res = 8'd32;
    if (code >= 8'd128) begin
      res = code;
    end else if (code >= 8'd32 && code <= 8'd63) begin
      res = code;
    end else if (code >= 8'd64 && code <= 8'd95) begin
      res = code - 8'd64;
    end else if (code >= 8'd97 && code <= 8'd122) begin
      res = code - 8'd96;
    end
    return res;
  endfunction

endpackage

/* rtl/core/text_cell_number_writer.sv */
// Character cell write generator top level
//
//   channel   handshake              payload
//   command   start / busy           func_i column_i row_i char_code_i number_i colour_i
//   write     out_strobe_o (1 cyc)   cell_offset_o screen_code_o cell_colour_o last_write_o
//
// A character command goes from accept straight to the push state; a number command
// first runs one divide-by-ten step per cycle, one step per decimal digit.
// The sequencer loads a command while idle, then issues one write per cycle until its last.
// Reset clears the front end state, queue pointers and sequencer; no payload is cleared.
// busy stays high while the front end works or waits for room in the two-entry queue;
// writes are never held off, the receiver takes each strobe as it comes.
`timescale 1ns / 1ps
module text_cell_number_writer #(
  parameter int unsigned COLUMNS = 22
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic        func_i,
  input  logic [7:0]  column_i,
  input  logic [7:0]  row_i,
  input  logic [7:0]  char_code_i,
  input  logic [15:0] number_i,
  input  logic [7:0]  colour_i,
  output logic        out_strobe_o,
  output logic [15:0] cell_offset_o,
  output logic [7:0]  screen_code_o,
  output logic [7:0]  cell_colour_o,
  output logic        last_write_o
);

  tcnw_pkg::cmd_t push_entry, pop_entry;
  logic           push, pop, full, empty;

  tcnw_front #(
    .COLUMNS(COLUMNS)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start      (start),
    .busy       (busy),
    .func_i     (func_i),
    .column_i   (column_i),
    .row_i      (row_i),
    .char_code_i(char_code_i),
    .number_i   (number_i),
    .colour_i   (colour_i),
    .q_full_i   (full),
    .q_push_o   (push),
    .q_entry_o  (push_entry)
  );

  tcnw_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .entry_i(push_entry),
    .full_o (full),
    .pop_i  (pop),
    .entry_o(pop_entry),
    .empty_o(empty)
  );

  tcnw_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .q_empty_i    (empty),
    .q_entry_i    (pop_entry),
    .q_pop_o      (pop),
    .out_strobe_o (out_strobe_o),
    .cell_offset_o(cell_offset_o),
    .screen_code_o(screen_code_o),
    .cell_colour_o(cell_colour_o),
    .last_write_o (last_write_o)
  );

endmodule

/* rtl/core/tcnw_front.sv */
// Command front end: accept, map characters and split numbers into digits
`timescale 1ns / 1ps
module tcnw_front #(
  parameter int unsigned COLUMNS = 22
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start,
  output logic               busy,
  input  logic               func_i,
  input  logic [7:0]         column_i,
  input  logic [7:0]         row_i,
  input  logic [7:0]         char_code_i,
  input  logic [15:0]        number_i,
  input  logic [7:0]         colour_i,
  input  logic               q_full_i,
  output logic               q_push_o,
  output tcnw_pkg::cmd_t     q_entry_o
);

  tcnw_pkg::front_state_e state_q, state_d;
  tcnw_pkg::cmd_t         cmd_q, cmd_d;
  logic [15:0]            num_q, num_d;
  logic [31:0]            prod;
  logic [15:0]            quot;
  logic [15:0]            rem;
  logic                   accept;

  assign accept = start && !busy;
  assign prod   = 32'(num_q) * 32'(tcnw_pkg::DIV10_MUL);
  assign quot   = 16'(prod >> tcnw_pkg::DIV10_SHIFT);
  assign rem    = num_q - ((quot << 3) + (quot << 1));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= tcnw_pkg::FS_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q <= cmd_d;
    num_q <= num_d;
  end

  always_comb begin
    state_d   = state_q;
    cmd_d     = cmd_q;
    num_d     = num_q;
    busy      = 1'b1;
    q_push_o  = 1'b0;
    q_entry_o = cmd_q;
    case (state_q)
      tcnw_pkg::FS_IDLE: begin
        busy = 1'b0;
        if (accept) begin
          cmd_d.base   = 16'(16'(row_i) * 16'(COLUMNS));
          cmd_d.column = column_i;
          cmd_d.colour = colour_i;
          cmd_d.is_num = func_i;
          cmd_d.code   = tcnw_pkg::map_code(char_code_i);
          cmd_d.count  = func_i ? '0 : tcnw_pkg::CNT_W'(1);
          num_d        = number_i;
          state_d      = func_i ? tcnw_pkg::FS_CONV : tcnw_pkg::FS_PUSH;
        end
      end
      tcnw_pkg::FS_CONV: begin
        cmd_d.digits[cmd_q.count] = rem[3:0];
        cmd_d.count               = cmd_q.count + 1'b1;
        num_d                     = quot;
        if (quot == '0) begin
          state_d = tcnw_pkg::FS_PUSH;
        end
      end
      tcnw_pkg::FS_PUSH: begin
        if (!q_full_i) begin
          q_push_o = 1'b1;
          state_d  = tcnw_pkg::FS_IDLE;
        end
      end
      default: begin
        state_d = tcnw_pkg::FS_IDLE;
      end
    endcase
  end

endmodule

/* rtl/core/tcnw_queue.sv */
// Two-entry command queue between front end and write sequencer
`timescale 1ns / 1ps
module tcnw_queue (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  tcnw_pkg::cmd_t entry_i,
  output logic           full_o,
  input  logic           pop_i,
  output tcnw_pkg::cmd_t entry_o,
  output logic           empty_o
);

  localparam int unsigned PTR_W = $clog2(tcnw_pkg::QDEPTH);

  tcnw_pkg::cmd_t   mem_q [tcnw_pkg::QDEPTH];
  logic [PTR_W-1:0] wptr_q, rptr_q;
  logic [PTR_W:0]   cnt_q;

  assign full_o  = (cnt_q == (PTR_W+1)'(tcnw_pkg::QDEPTH));
  assign empty_o = (cnt_q == '0);
  assign entry_o = mem_q[rptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wptr_q] <= entry_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      if (push_i) begin
        wptr_q <= wptr_q + 1'b1;
      end
      if (pop_i) begin
        rptr_q <= rptr_q + 1'b1;
      end
      cnt_q <= cnt_q + (PTR_W+1)'(push_i) - (PTR_W+1)'(pop_i);
    end
  end

endmodule

/* rtl/core/tcnw_back.sv */
// Write sequencer: one cell write per cycle while a command is active, most significant digit first
`timescale 1ns / 1ps
`include "text_cell_number_writer_defines.svh"
module tcnw_back (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               q_empty_i,
  input  tcnw_pkg::cmd_t     q_entry_i,
  output logic               q_pop_o,
  output logic               out_strobe_o,
  output logic [15:0]        cell_offset_o,
  output logic [7:0]         screen_code_o,
  output logic [7:0]         cell_colour_o,
  output logic               last_write_o
);

  tcnw_pkg::cmd_t                  cmd_q;
  logic                            active_q;
  logic [tcnw_pkg::CNT_W-1:0]      idx_q;
  logic [7:0]                      col_q;
  logic [7:0]                      code;

  assign q_pop_o = !active_q && !q_empty_i;
  assign code    = cmd_q.is_num
                 ? tcnw_pkg::map_code(tcnw_pkg::DIGIT_ZERO + 8'(cmd_q.digits[idx_q]))
                 : cmd_q.code;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q     <= 1'b0;
      out_strobe_o <= 1'b0;
    end else begin
      out_strobe_o <= active_q;
      if (q_pop_o) begin
        active_q <= 1'b1;
      end else if (active_q && idx_q == '0) begin
        active_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (q_pop_o) begin
      cmd_q <= q_entry_i;
      idx_q <= q_entry_i.count - 1'b1;
      col_q <= q_entry_i.column;
    end else if (active_q) begin
      idx_q <= idx_q - 1'b1;
      col_q <= col_q + 1'b1;
    end
    cell_offset_o <= cmd_q.base + 16'(col_q);
    screen_code_o <= code;
    cell_colour_o <= cmd_q.colour;
    last_write_o  <= (idx_q == '0);
  end

  `TCNW_ASSERT(run_unbroken_a, clk_i, rst_ni, out_strobe_o && !last_write_o |=> out_strobe_o)
  `TCNW_ASSERT(last_follows_a, clk_i, rst_ni, active_q && idx_q == '0 |=> out_strobe_o && last_write_o)
  `TCNW_ASSERT(digit_code_a, clk_i, rst_ni, out_strobe_o && !last_write_o |-> screen_code_o >= tcnw_pkg::DIGIT_ZERO && screen_code_o <= tcnw_pkg::DIGIT_NINE)

endmodule

/* tb/tb_text_cell_number_writer.sv */
// Self-checking testbench for the character cell write generator
`timescale 1ns / 1ps
module tb_text_cell_number_writer;

  localparam int unsigned COLUMNS        = 22;
  localparam int unsigned HALF_PERIOD    = 6;
  localparam int unsigned TAIL_CYCLES    = 32;
  localparam int unsigned WATCHDOG_LIMIT = 2000;
  localparam int unsigned PHASE_ITEMS    = 43;
  localparam int unsigned NUM_DIRECTED   = 22;

  typedef enum logic {
    FN_CHAR   = 1'b0,
    FN_NUMBER = 1'b1
  } cmd_func_e;

  typedef struct packed {
    cmd_func_e   func;
    logic [7:0]  column;
    logic [7:0]  row;
    logic [7:0]  char_code;
    logic [15:0] number;
    logic [7:0]  colour;
  } screen_cmd_t;

  typedef struct packed {
    logic [15:0] offset;
    logic [7:0]  code;
    logic [7:0]  colour;
    logic        last;
  } cell_write_t;

  typedef struct packed {
    screen_cmd_t cmd;
    logic        typed;
    logic [15:0] exp_offset;
    logic [7:0]  exp_code;
  } directed_row_t;

  logic        clk_i;
  logic        rst_ni;
  logic        start;
  logic        busy;
  logic        func_i;
  logic [7:0]  column_i;
  logic [7:0]  row_i;
  logic [7:0]  char_code_i;
  logic [15:0] number_i;
  logic [7:0]  colour_i;
  logic        out_strobe_o;
  logic [15:0] cell_offset_o;
  logic [7:0]  screen_code_o;
  logic [7:0]  cell_colour_o;
  logic        last_write_o;

  cell_write_t pending_writes[$];
  cell_write_t oldest_write;
  int unsigned err_cnt;
  int unsigned quiet_cycles;
  int unsigned sender_idle_pct;

  directed_row_t directed_tbl [NUM_DIRECTED] = '{
    '{'{FN_CHAR,   8'd0,   8'd0,   8'd65,  16'd0,     8'h00}, 1'b1, 16'd0,    8'd1},
    '{'{FN_CHAR,   8'd255, 8'd255, 8'd32,  16'hFFFF,  8'hFF}, 1'b1, 16'd5865, 8'd32},
    '{'{FN_CHAR,   8'd1,   8'd1,   8'd63,  16'd0,     8'h55}, 1'b1, 16'd23,   8'd63},
    '{'{FN_CHAR,   8'd2,   8'd1,   8'd64,  16'd0,     8'h01}, 1'b1, 16'd24,   8'd0},
    '{'{FN_CHAR,   8'd3,   8'd1,   8'd95,  16'd0,     8'h02}, 1'b1, 16'd25,   8'd31},
    '{'{FN_CHAR,   8'd4,   8'd1,   8'd96,  16'd0,     8'h04}, 1'b1, 16'd26,   8'd32},
    '{'{FN_CHAR,   8'd5,   8'd1,   8'd97,  16'd0,     8'h08}, 1'b1, 16'd27,   8'd1},
    '{'{FN_CHAR,   8'd6,   8'd1,   8'd122, 16'd0,     8'h10}, 1'b1, 16'd28,   8'd26},
    '{'{FN_CHAR,   8'd7,   8'd1,   8'd123, 16'd0,     8'h20}, 1'b1, 16'd29,   8'd32},
    '{'{FN_CHAR,   8'd8,   8'd1,   8'd127, 16'd0,     8'h40}, 1'b1, 16'd30,   8'd32},
    '{'{FN_CHAR,   8'd0,   8'd2,   8'd0,   16'd0,     8'h80}, 1'b1, 16'd44,   8'd32},
    '{'{FN_CHAR,   8'd1,   8'd2,   8'd31,  16'd0,     8'h0F}, 1'b1, 16'd45,   8'd32},
    '{'{FN_CHAR,   8'd2,   8'd2,   8'd128, 16'd0,     8'hF0}, 1'b1, 16'd46,   8'd128},
    '{'{FN_CHAR,   8'd3,   8'd2,   8'd255, 16'd65535, 8'h3C}, 1'b1, 16'd47,   8'd255},
    '{'{FN_NUMBER, 8'd0,   8'd3,   8'd200, 16'd0,     8'h5A}, 1'b1, 16'd66,   8'd48},
    '{'{FN_NUMBER, 8'd255, 8'd3,   8'd0,   16'd7,     8'hA5}, 1'b1, 16'd321,  8'd55},
    '{'{FN_NUMBER, 8'd0,   8'd4,   8'd0,   16'd65535, 8'h11}, 1'b0, 16'd0,    8'd0},
    '{'{FN_NUMBER, 8'd253, 8'd5,   8'd65,  16'd12345, 8'h22}, 1'b0, 16'd0,    8'd0},
    '{'{FN_NUMBER, 8'd10,  8'd6,   8'd0,   16'd10,    8'h33}, 1'b0, 16'd0,    8'd0},
    '{'{FN_NUMBER, 8'd0,   8'd7,   8'd0,   16'd10000, 8'h44}, 1'b0, 16'd0,    8'd0},
    '{'{FN_NUMBER, 8'd254, 8'd255, 8'd255, 16'd99,    8'hEE}, 1'b0, 16'd0,    8'd0},
    '{'{FN_CHAR,   8'd0,   8'd0,   8'hAA,  16'h5555,  8'hAA}, 1'b1, 16'd0,    8'd170}
  };

  text_cell_number_writer #(
    .COLUMNS(COLUMNS)
  ) DUT (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start        (start),
    .busy         (busy),
    .func_i       (func_i),
    .column_i     (column_i),
    .row_i        (row_i),
    .char_code_i  (char_code_i),
    .number_i     (number_i),
    .colour_i     (colour_i),
    .out_strobe_o (out_strobe_o),
    .cell_offset_o(cell_offset_o),
    .screen_code_o(screen_code_o),
    .cell_colour_o(cell_colour_o),
    .last_write_o (last_write_o)
  );

  always begin
    clk_i = 1'b1;
    #(HALF_PERIOD);
    clk_i = 1'b0;
    #(HALF_PERIOD);
  end

  function automatic logic [7:0] to_screen_code(input logic [7:0] ascii);
    logic [7:0] code;
    code = 8'd32;
    if (ascii >= 8'd128) begin
      code = ascii;
    end else if (ascii >= 8'd32 && ascii <= 8'd63) begin
      code = ascii;
    end else if (ascii >= 8'd64 && ascii <= 8'd95) begin
      code = ascii - 8'd64;
    end else if (ascii >= 8'd97 && ascii <= 8'd122) begin
      code = ascii - 8'd96;
    end
    return code;
  endfunction

  function automatic logic [15:0] cell_index(input logic [7:0] row, input logic [7:0] col);
    int unsigned idx;
    idx = int'(row) * COLUMNS + int'(col);
    return idx[15:0];
  endfunction

  // Queue the writes a command produces, most significant digit first.
  function automatic void predict_writes(input screen_cmd_t cmd);
    logic [3:0]  digs [5];
    int          cnt;
    logic [15:0] rest;
    logic [7:0]  col;
    cell_write_t wr;
    cnt  = 0;
    rest = cmd.number;
    col  = cmd.column;
    wr.colour = cmd.colour;
    if (cmd.func == FN_CHAR || cmd.number == 16'd0) begin
      wr.offset = cell_index(cmd.row, col);
      wr.code   = (cmd.func == FN_CHAR) ? to_screen_code(cmd.char_code) : 8'd48;
      wr.last   = 1'b1;
      pending_writes.push_back(wr);
    end else begin
      while (rest != 16'd0 && cnt < 5) begin
        digs[cnt] = 4'(rest % 16'd10);
        rest      = rest / 16'd10;
        cnt++;
      end
      for (int k = cnt - 1; k >= 0; k--) begin
        wr.offset = cell_index(cmd.row, col);
        wr.code   = 8'd48 + 8'(digs[k]);
        wr.last   = (k == 0);
        pending_writes.push_back(wr);
        col = col + 8'd1;
      end
    end
  endfunction

  function automatic screen_cmd_t random_cmd();
    screen_cmd_t cmd;
    int unsigned sel;
    int unsigned ndig;
    cmd.func      = cmd_func_e'($urandom_range(1));
    cmd.row       = 8'($urandom);
    cmd.char_code = 8'($urandom);
    cmd.colour    = 8'($urandom);
    cmd.column    = ($urandom_range(3) == 0) ? 8'($urandom_range(255, 250)) : 8'($urandom);
    sel = $urandom_range(9);
    case (sel)
      0: begin
        cmd.number = 16'd0;
      end
      1: begin
        cmd.number = 16'hFFFF;
      end
      2: begin
        cmd.number = 16'($urandom);
      end
      default: begin
        ndig = $urandom_range(5, 1);
        case (ndig)
          1: cmd.number = 16'($urandom_range(9, 1));
          2: cmd.number = 16'($urandom_range(99, 10));
          3: cmd.number = 16'($urandom_range(999, 100));
          4: cmd.number = 16'($urandom_range(9999, 1000));
          default: cmd.number = 16'($urandom_range(65535, 10000));
        endcase
      end
    endcase
    return cmd;
  endfunction

  task automatic report_mismatch(input string what, input int unsigned got,
                                 input int unsigned exp);
    $display("%0t: %s mismatch: got %0d, expected %0d", $realtime, what, got, exp);
    err_cnt++;
  endtask

  // Drive one command and hold it until the block takes it.
  task automatic issue_cmd(input screen_cmd_t cmd);
    while ($urandom_range(99) < sender_idle_pct) begin
      start <= 1'b0;
      @(posedge clk_i);
    end
    start       <= 1'b1;
    func_i      <= cmd.func;
    column_i    <= cmd.column;
    row_i       <= cmd.row;
    char_code_i <= cmd.char_code;
    number_i    <= cmd.number;
    colour_i    <= cmd.colour;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    predict_writes(cmd);
  endtask

  task automatic drain_writes();
    start <= 1'b0;
    while (pending_writes.size() != 0) @(posedge clk_i);
    repeat (TAIL_CYCLES) @(posedge clk_i);
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && out_strobe_o) begin
      if (pending_writes.size() == 0) begin
        report_mismatch("unexpected write, offset", 32'(cell_offset_o), 0);
      end else begin
        oldest_write = pending_writes.pop_front();
        if (cell_offset_o !== oldest_write.offset)
          report_mismatch("cell_offset", 32'(cell_offset_o), 32'(oldest_write.offset));
        if (screen_code_o !== oldest_write.code)
          report_mismatch("screen_code", 32'(screen_code_o), 32'(oldest_write.code));
        if (cell_colour_o !== oldest_write.colour)
          report_mismatch("cell_colour", 32'(cell_colour_o), 32'(oldest_write.colour));
        if (last_write_o !== oldest_write.last)
          report_mismatch("last_write", 32'(last_write_o), 32'(oldest_write.last));
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || out_strobe_o || (start && !busy)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: watchdog, no transfer for %0d cycles", $realtime, quiet_cycles);
      $display("Testbench completed WITH ERRORS");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    screen_cmd_t typed_cmd;
    cell_write_t typed_write;
    err_cnt         = 0;
    sender_idle_pct = 36;
    rst_ni      = 1'b0;
    start       = 1'b0;
    func_i      = FN_CHAR;
    column_i    = 8'd0;
    row_i       = 8'd0;
    char_code_i = 8'd0;
    number_i    = 16'd0;
    colour_i    = 8'd0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int i = 0; i < NUM_DIRECTED; i++) begin
      if (directed_tbl[i].typed) begin
        typed_cmd = directed_tbl[i].cmd;
        // Swap the predicted write for the one written into the table.
        issue_cmd(typed_cmd);
        typed_write = pending_writes.pop_back();
        typed_write.offset = directed_tbl[i].exp_offset;
        typed_write.code   = directed_tbl[i].exp_code;
        typed_write.colour = typed_cmd.colour;
        typed_write.last   = 1'b1;
        pending_writes.push_back(typed_write);
      end else begin
        issue_cmd(directed_tbl[i].cmd);
      end
    end
    drain_writes();

    for (int phase = 0; phase < 3; phase++) begin
      sender_idle_pct = (phase == 0) ? 36 : (phase == 1) ? 72 : 0;
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        issue_cmd(random_cmd());
      end
      drain_writes();
    end

    if (err_cnt == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
